### rtl/core/sotu_pkg.sv
// Shared types and constants for the square tile orientation transform.
// No dependencies; imported by the front end, queue, emitter and top level.
package sotu_pkg;

  localparam int MODE_W     = 3;
  localparam int SIZE_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [MODE_W-1:0] MODE_TRANSPOSE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ANTI_TRANS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROTATE_180 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLIP_ROWS  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLIP_COLS  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SWAP_MID   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [MODE_W-1:0] mode;
  } tile_cmd_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

endpackage

### rtl/core/sotu_front.sv
// Front end: configuration registers, element intake and tile store writes.
// Pushes one tile command per completed tile. Depends on sotu_pkg.
module sotu_front #(
  parameter int MAX_SIZE      = 8,
  parameter int ELEMENT_WIDTH = 16,
  parameter int ADDR_W        = 6,
  parameter int CNT_W         = 7
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sotu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sotu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ELEMENT_WIDTH-1:0]         in_element,
  input  sotu_pkg::back_stat_t             back_stat,
  input  logic                             q_empty,
  output logic                             q_push,
  output sotu_pkg::tile_cmd_t              q_cmd,
  output logic                             mem_we,
  output logic [ADDR_W-1:0]                mem_waddr,
  output logic [ELEMENT_WIDTH-1:0]         mem_wdata
);
  import sotu_pkg::*;

  logic [MODE_W-1:0]   mode_r;
  logic [SIZE_W-1:0]   size_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt, cnt_inc;
  logic [SIZE_W-1:0]   size_eff;
  logic [2*SIZE_W-1:0] total_full;
  logic [CNT_W-1:0]    total;
  logic                accept, done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TRANSPOSE;
      size_r <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_data[MODE_W-1:0];
        REG_SIZE: size_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (size_r > SIZE_W'(MAX_SIZE)) begin
      size_eff = SIZE_W'(MAX_SIZE);
    end else begin
      size_eff = size_r;
    end
  end

  assign total_full = {{SIZE_W{1'b0}}, size_eff} * {{SIZE_W{1'b0}}, size_eff};
  assign total      = total_full[CNT_W-1:0];

  assign in_ready = q_empty & ~back_stat.busy;
  assign accept   = in_valid & in_ready;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign done     = (cnt_inc >= total);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = done ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign mem_we      = accept;
  assign mem_waddr   = cnt_r[ADDR_W-1:0];
  assign mem_wdata   = in_element;
  assign q_push      = accept & done;
  assign q_cmd.size  = size_eff;
  assign q_cmd.mode  = mode_r;

endmodule

### rtl/core/sotu_cmd_q.sv
// Two-entry command queue between the front end and the emitter.
// Depends on sotu_pkg.
module sotu_cmd_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sotu_pkg::tile_cmd_t push_cmd,
  input  logic                pop,
  output logic                empty,
  output sotu_pkg::tile_cmd_t head
);
  import sotu_pkg::*;

  tile_cmd_t   q_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign empty   = (cnt_r == 2'd0);
  assign do_pop  = pop & ~empty;
  assign do_push = push & (cnt_r != 2'd2);
  assign head    = q_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push & ~do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop & ~do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/core/sotu_back.sv
// Emitter: tile store, reorientation address sequencer and output buffer.
// Depends on sotu_pkg.
module sotu_back #(
  parameter int MAX_SIZE      = 8,
  parameter int ELEMENT_WIDTH = 16,
  parameter int ADDR_W        = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     mem_we,
  input  logic [ADDR_W-1:0]        mem_waddr,
  input  logic [ELEMENT_WIDTH-1:0] mem_wdata,
  input  logic                     q_valid,
  input  sotu_pkg::tile_cmd_t      q_head,
  output logic                     q_pop,
  output sotu_pkg::back_stat_t     back_stat,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ELEMENT_WIDTH-1:0] out_element,
  output logic                     out_last
);
  import sotu_pkg::*;

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;

  logic [ELEMENT_WIDTH-1:0] store_r [DEPTH];

  logic                active_r;
  logic [SIZE_W-1:0]   n_r, i_r, j_r;
  logic [MODE_W-1:0]   mode_r;
  logic [SIZE_W-1:0]   e, h, partner, src_r, src_c;
  logic [2*SIZE_W-1:0] lin;
  logic [ADDR_W-1:0]   raddr;
  logic                issue, last_pos, pop_out;
  logic [2:0]          occ;

  logic                     rd_valid_r, rd_last_r;
  logic [ELEMENT_WIDTH-1:0] rd_data_r;

  logic [ELEMENT_WIDTH-1:0] of_data_r [2];
  logic                     of_last_r [2];
  logic                     of_wptr_r, of_rptr_r;
  logic [1:0]               of_cnt_r, of_cnt_nxt;

  assign e       = n_r - SIZE_W'(1);
  assign h       = n_r >> 1;
  assign partner = (h << 1) - j_r;

  always_comb begin
    src_r = i_r;
    src_c = j_r;
    case (mode_r)
      MODE_TRANSPOSE: begin
        src_r = j_r;
        src_c = i_r;
      end
      MODE_ANTI_TRANS: begin
        src_r = e - j_r;
        src_c = e - i_r;
      end
      MODE_ROTATE_180: begin
        src_r = e - i_r;
        src_c = e - j_r;
      end
      MODE_FLIP_ROWS: begin
        src_r = e - i_r;
      end
      MODE_FLIP_COLS: begin
        src_c = e - j_r;
      end
      MODE_SWAP_MID: begin
        if (((j_r + SIZE_W'(1)) == h || j_r == (h + SIZE_W'(1))) && partner < n_r) begin
          src_c = partner;
        end
      end
      default: ;
    endcase
  end

  assign lin   = {{SIZE_W{1'b0}}, src_r} * {{SIZE_W{1'b0}}, n_r} + {{SIZE_W{1'b0}}, src_c};
  assign raddr = lin[ADDR_W-1:0];

  assign pop_out  = out_valid & out_ready;
  assign occ      = {1'b0, of_cnt_r} + {2'b0, rd_valid_r} - {2'b0, pop_out};
  assign issue    = active_r & (occ < 3'd2);
  assign last_pos = (i_r == e) & (j_r == e);
  assign q_pop    = ~active_r & q_valid;

  assign back_stat.busy = active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= issue;
      if (q_pop) begin
        active_r <= 1'b1;
      end else if (issue & last_pos) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      n_r    <= q_head.size;
      mode_r <= q_head.mode;
      i_r    <= '0;
      j_r    <= '0;
    end else if (issue) begin
      if (j_r == e) begin
        j_r <= '0;
        i_r <= i_r + SIZE_W'(1);
      end else begin
        j_r <= j_r + SIZE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data_r <= store_r[raddr];
      rd_last_r <= last_pos;
    end
  end

  always_comb begin
    of_cnt_nxt = of_cnt_r;
    if (rd_valid_r & ~pop_out) begin
      of_cnt_nxt = of_cnt_r + 2'd1;
    end else if (pop_out & ~rd_valid_r) begin
      of_cnt_nxt = of_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_cnt_r  <= 2'd0;
      of_wptr_r <= 1'b0;
      of_rptr_r <= 1'b0;
    end else begin
      of_cnt_r <= of_cnt_nxt;
      if (rd_valid_r) begin
        of_wptr_r <= ~of_wptr_r;
      end
      if (pop_out) begin
        of_rptr_r <= ~of_rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      of_data_r[of_wptr_r] <= rd_data_r;
      of_last_r[of_wptr_r] <= rd_last_r;
    end
  end

  assign out_valid   = (of_cnt_r != 2'd0);
  assign out_element = of_data_r[of_rptr_r];
  assign out_last    = of_last_r[of_rptr_r];

endmodule

### rtl/core/square_tile_orientation_transform_unit.sv
// Square tile orientation transform: (anti-)transpose, flip, rotate, mid swap.
// Top level; instantiates sotu_front, sotu_cmd_q and sotu_back; uses sotu_pkg.
//
// Usage:
//   cfg_*  : register writes (index 0 mode, index 1 tile size); cfg_ready is
//            always high. Write only while no tile is being emitted.
//   in_*   : tile elements in row-major order, one transaction per element,
//            up to one per cycle while a tile loads.
//   out_*  : the reoriented tile in row-major order, out_last on its final
//            element.
// Output: the tile's command passes the command queue to the emitter, then
//   each element passes the store read register and the output buffer;
//   results follow one per cycle while out_ready stays high.
// Tile sequence: an n x n tile is loaded, handed to the emitter and emitted,
//   one store read per cycle (single read port) while the output buffer has
//   room. in_ready drops from the completing element until the last read issues.
// Reset: clears the element count, queue and output buffer; mode returns to
//   transpose and the tile size to 8. The tile store is not cleared.
// Receiver stall: a two-entry output buffer absorbs the read in flight; store
//   reads pause while the buffer is full, nothing is dropped.
module square_tile_orientation_transform_unit #(
  parameter int MAX_SIZE      = 8,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sotu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sotu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ELEMENT_WIDTH-1:0]        in_element,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ELEMENT_WIDTH-1:0]        out_element,
  output logic                            out_last
);
  import sotu_pkg::*;

  localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  back_stat_t               back_stat;
  tile_cmd_t                push_cmd, head_cmd;
  logic                     q_push, q_pop, q_empty;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;

  sotu_front #(
    .MAX_SIZE      (MAX_SIZE),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .ADDR_W        (ADDR_W),
    .CNT_W         (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_element (in_element),
    .back_stat  (back_stat),
    .q_empty    (q_empty),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata)
  );

  sotu_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  sotu_back #(
    .MAX_SIZE      (MAX_SIZE),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .ADDR_W        (ADDR_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .q_valid     (~q_empty),
    .q_head      (head_cmd),
    .q_pop       (q_pop),
    .back_stat   (back_stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_element (out_element),
    .out_last    (out_last)
  );

endmodule

### rtl/core/sotu_checker.sv
// Port-level checks for square_tile_orientation_transform_unit, bound to it.
// Depends on the top level it is bound to.
module sotu_checker #(
  parameter int ELEMENT_WIDTH = 16
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ELEMENT_WIDTH-1:0]        out_element,
  input logic                            out_last
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // intake closes only after an element was taken
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid))
    else $error("in_ready dropped without an input transaction");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind square_tile_orientation_transform_unit sotu_checker #(
  .ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_sotu_checker (.*);
